>>> src/blist_pkg.sv
// blist_pkg: shared constants, request/response types and slot address helper
// for the bounded ordered list. No dependencies.
package blist_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;
	localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [2:0] {
		KIND_APPEND       = 3'd0,
		KIND_INSERT_FRONT = 3'd1,
		KIND_REMOVE_FRONT = 3'd2,
		KIND_REMOVE_KEY   = 3'd3,
		KIND_CONTAINS     = 3'd4,
		KIND_READ         = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [DATA_W-1:0]  value;
		logic        [POS_W-1:0]   position;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  read_value;
		logic                      hit;
		status_t                   status;
		logic        [COUNT_W-1:0] count;
		logic                      empty_res;
	} rsp_t;

	// physical slot of logical offset off in the ring starting at head
	function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] head,
		input logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, head} + {1'b0, off};
		if (sum >= (IDX_W + 1)'(DEPTH))
			sum = sum - (IDX_W + 1)'(DEPTH);
		return sum[IDX_W-1:0];
	endfunction

endpackage

>>> src/blist_ram.sv
// blist_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
module blist_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> src/bounded_ordered_list.sv
// Bounded ordered list kept as a ring in one RAM (head pointer plus count).
// Append, insert front, remove front, rejected and unknown requests go straight to the finish state.
// Read at index passes through a read-wait state; contains scans entries up to the match or the last one.
// Remove key: search as above, then the shift state moves each entry after the match down one slot.
// One request at a time: the next is taken in the cycle after the response loads.
// Reset empties the list (count and head cleared); RAM contents are never cleared.
module bounded_ordered_list (
	input  logic              clk,
	input  logic              arst_n,
	input  blist_pkg::req_t   req,
	input  logic              req_valid,
	output logic              req_stall,
	output blist_pkg::rsp_t   rsp,
	output logic              rsp_valid,
	input  logic              rsp_stall
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RDWAIT,
		S_FINISH
	} state_t;

	state_t                                  state_q;
	logic [blist_pkg::CNT_W-1:0]             count_q;
	logic [blist_pkg::IDX_W-1:0]             head_q;
	logic [blist_pkg::IDX_W-1:0]             idx_q;
	blist_pkg::kind_t                        kind_q;
	logic signed [blist_pkg::DATA_W-1:0]     value_q;
	logic signed [blist_pkg::DATA_W-1:0]     rd_q;
	logic                                    hit_q;
	blist_pkg::status_t                      status_q;
	blist_pkg::rsp_t                         rsp_q;
	logic                                    rsp_valid_q;

	logic                                    accept;
	logic                                    full;
	logic                                    empty;
	logic                                    pos_ok;
	logic                                    scan_last;
	logic                                    shift_last;
	logic                                    match;
	logic [blist_pkg::IDX_W-1:0]             head_inc;
	logic [blist_pkg::IDX_W-1:0]             head_dec;
	logic                                    ram_we;
	logic [blist_pkg::IDX_W-1:0]             ram_waddr;
	logic [blist_pkg::DATA_W-1:0]            ram_wdata;
	logic [blist_pkg::IDX_W-1:0]             ram_raddr;
	logic [blist_pkg::DATA_W-1:0]            ram_rdata;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign full   = (count_q == blist_pkg::CNT_W'(blist_pkg::DEPTH));
	assign empty  = (count_q == '0);
	assign pos_ok = (blist_pkg::CMP_W'(req.position) < blist_pkg::CMP_W'(count_q));
	assign match  = ($signed(ram_rdata) == value_q);

	assign scan_last  = ((blist_pkg::CNT_W'(idx_q) + blist_pkg::CNT_W'(1)) == count_q);
	assign shift_last = ((blist_pkg::CNT_W'(idx_q) + blist_pkg::CNT_W'(2)) == count_q);

	assign head_inc = (head_q == blist_pkg::IDX_W'(blist_pkg::DEPTH - 1)) ?
		'0 : head_q + blist_pkg::IDX_W'(1);
	assign head_dec = (head_q == '0) ?
		blist_pkg::IDX_W'(blist_pkg::DEPTH - 1) : head_q - blist_pkg::IDX_W'(1);

	// RAM port control; the scan keeps one read in flight ahead of the compare
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = blist_pkg::slot_addr(head_q, blist_pkg::IDX_W'(count_q));
		ram_wdata = req.value;
		ram_raddr = head_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.kind)
						blist_pkg::KIND_APPEND: begin
							ram_we = !full;
						end
						blist_pkg::KIND_INSERT_FRONT: begin
							ram_we    = !full;
							ram_waddr = head_dec;
						end
						blist_pkg::KIND_READ: begin
							ram_raddr = blist_pkg::slot_addr(head_q,
								blist_pkg::IDX_W'(req.position));
						end
						default: begin
							ram_raddr = head_q;
						end
					endcase
				end
			end
			S_SCAN: begin
				ram_raddr = blist_pkg::slot_addr(head_q, idx_q + blist_pkg::IDX_W'(1));
			end
			S_SHIFT: begin
				// move entry idx+1 down into idx, fetch idx+2
				ram_we    = 1'b1;
				ram_waddr = blist_pkg::slot_addr(head_q, idx_q);
				ram_wdata = ram_rdata;
				ram_raddr = blist_pkg::slot_addr(head_q, idx_q + blist_pkg::IDX_W'(2));
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	blist_ram #(
		.WIDTH (blist_pkg::DATA_W),
		.DEPTH (blist_pkg::DEPTH),
		.ADDR_W(blist_pkg::IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			idx_q       <= '0;
			kind_q      <= blist_pkg::KIND_APPEND;
			value_q     <= '0;
			rd_q        <= '0;
			hit_q       <= 1'b0;
			status_q    <= blist_pkg::ST_DONE;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// the finish state reloads the response itself
			if (rsp_valid_q && !rsp_stall && state_q != S_FINISH)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q  <= req.kind;
						value_q <= req.value;
						rd_q    <= '0;
						hit_q   <= (req.kind == blist_pkg::KIND_REMOVE_FRONT) && !empty;
						idx_q   <= '0;
						case (req.kind)
							blist_pkg::KIND_APPEND: begin
								state_q <= S_FINISH;
								if (full) begin
									status_q <= blist_pkg::ST_FULL;
								end else begin
									status_q <= blist_pkg::ST_DONE;
									count_q  <= count_q + blist_pkg::CNT_W'(1);
								end
							end
							blist_pkg::KIND_INSERT_FRONT: begin
								state_q <= S_FINISH;
								if (full) begin
									status_q <= blist_pkg::ST_FULL;
								end else begin
									status_q <= blist_pkg::ST_DONE;
									head_q   <= head_dec;
									count_q  <= count_q + blist_pkg::CNT_W'(1);
								end
							end
							blist_pkg::KIND_REMOVE_FRONT: begin
								state_q <= S_FINISH;
								if (empty) begin
									status_q <= blist_pkg::ST_NONE;
								end else begin
									status_q <= blist_pkg::ST_DONE;
									head_q   <= head_inc;
									count_q  <= count_q - blist_pkg::CNT_W'(1);
								end
							end
							blist_pkg::KIND_REMOVE_KEY: begin
								if (empty) begin
									status_q <= blist_pkg::ST_NONE;
									state_q  <= S_FINISH;
								end else begin
									status_q <= blist_pkg::ST_DONE;
									state_q  <= S_SCAN;
								end
							end
							blist_pkg::KIND_CONTAINS: begin
								status_q <= blist_pkg::ST_DONE;
								state_q  <= empty ? S_FINISH : S_SCAN;
							end
							blist_pkg::KIND_READ: begin
								if (pos_ok) begin
									status_q <= blist_pkg::ST_DONE;
									state_q  <= S_RDWAIT;
								end else begin
									status_q <= blist_pkg::ST_NONE;
									state_q  <= S_FINISH;
								end
							end
							default: begin
								status_q <= blist_pkg::ST_NONE;
								state_q  <= S_FINISH;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (match) begin
						hit_q <= 1'b1;
						if (kind_q == blist_pkg::KIND_REMOVE_KEY && !scan_last) begin
							state_q <= S_SHIFT;
						end else begin
							if (kind_q == blist_pkg::KIND_REMOVE_KEY)
								count_q <= count_q - blist_pkg::CNT_W'(1);
							state_q <= S_FINISH;
						end
					end else if (scan_last) begin
						if (kind_q == blist_pkg::KIND_REMOVE_KEY)
							status_q <= blist_pkg::ST_NONE;
						state_q <= S_FINISH;
					end else begin
						idx_q <= idx_q + blist_pkg::IDX_W'(1);
					end
				end
				S_SHIFT: begin
					if (shift_last) begin
						count_q <= count_q - blist_pkg::CNT_W'(1);
						state_q <= S_FINISH;
					end else begin
						idx_q <= idx_q + blist_pkg::IDX_W'(1);
					end
				end
				S_RDWAIT: begin
					rd_q    <= $signed(ram_rdata);
					hit_q   <= 1'b1;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.read_value <= rd_q;
						rsp_q.hit        <= hit_q;
						rsp_q.status     <= status_q;
						rsp_q.count      <= blist_pkg::COUNT_W'(count_q);
						rsp_q.empty_res  <= (count_q == '0);
						rsp_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= blist_pkg::CNT_W'(blist_pkg::DEPTH))
		else $error("entry count above depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> blist_pkg::CNT_W'(idx_q) < count_q)
		else $error("scan index past count");

	a_shift_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> kind_q == blist_pkg::KIND_REMOVE_KEY && hit_q)
		else $error("compaction without a removed key");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == blist_pkg::ST_FULL |->
		!rsp_q.hit && rsp_q.count == blist_pkg::COUNT_W'(blist_pkg::DEPTH))
		else $error("full rejection with inconsistent response");

	a_hit_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.hit |-> rsp_q.status == blist_pkg::ST_DONE)
		else $error("hit reported with error status");

endmodule
